>>> rtl/q2e_pkg.sv
// Shared constants, types and functions for the quaternion to Euler pipeline.
`timescale 1ns / 1ps
package q2e_pkg;
   localparam int QUAT_FRAC_BITS_DEF  = 14;
   localparam int ANGLE_FRAC_BITS_DEF = 7;
   localparam int CORDIC_STAGES_DEF   = 16;
   localparam int WORK_FRAC = 30;
   localparam int DEG_FRAC  = 24;
   localparam int VW        = 50;   // CORDIC x/y width
   localparam int ZW        = 36;   // angle accumulator width, degrees * 2^24
   localparam int IN_W      = 16;
   localparam int PITCH_W   = 15;
   localparam int ANG_W     = 16;

   typedef logic signed [VW-1:0] vec_type;
   typedef logic signed [ZW-1:0] ang_type;

   // One CORDIC lane: vector plus angle plus a bypass flag for the trivial cases.
   typedef struct packed {
      vec_type x;
      vec_type y;
      ang_type z;
      logic    done;
   } lane_type;

   function automatic ang_type atan_tab(input int i);
      logic [31:0] t [32];
      t = '{32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
            32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
            32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
            32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229,
            32'd115, 32'd57, 32'd29, 32'd14, 32'd7, 32'd4, 32'd2, 32'd1, 32'd0};
      return ang_type'({4'd0, t[i[4:0]]});
   endfunction
endpackage

>>> rtl/quaternion_to_euler.sv
// Top level: quaternion in, Z-Y-X Euler angles in degrees out, fully pipelined.
//
//  channel | direction | word contents
//  req_    | in        | tdata: q_w, q_x, q_y, q_z (16 bits each, signed Q1.14)
//  rsp_    | out       | tdata: pitch_deg[14:0], roll_deg[30:15], yaw_deg[46:31], zero pad
//
//  One word per cycle while the pipe advances: 37 front-end stages with a 31-cell
//  square root, then one CORDIC cell per stage, then the output register. The
//  whole pipe advances only when the output register is empty or being taken;
//  req_tready drops whenever a finished word waits untaken.
//  Synchronous active-high reset clears every valid bit; payload is not reset.
`timescale 1ns / 1ps
module quaternion_to_euler #(
   parameter int QUAT_FRAC_BITS  = q2e_pkg::QUAT_FRAC_BITS_DEF,
   parameter int ANGLE_FRAC_BITS = q2e_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STAGES   = q2e_pkg::CORDIC_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // q_w, q_x, q_y, q_z from bit 0 up
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // pitch_deg, roll_deg, yaw_deg from bit 0 up
);
   import q2e_pkg::*;
   localparam int NS = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
   localparam int S  = DEG_FRAC - ANGLE_FRAC_BITS;
   localparam int PW3 = PITCH_W + 2 * ANG_W;

   logic en;
   logic out_v_ff;
   logic [PW3-1:0] out_d_ff;

   logic     fv;
   lane_type fl [3];
   logic     cv [NS+1];
   lane_type cl [NS+1][3];
   logic [PW3-1:0] cp [NS+1];

   assign en = !out_v_ff || rsp_tready;
   assign req_tready = en;

   q2e_front #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_front (
      .clock, .reset, .en, .valid_in(req_tvalid),
      .q_w(req_tdata[15:0]), .q_x(req_tdata[31:16]),
      .q_y(req_tdata[47:32]), .q_z(req_tdata[63:48]),
      .valid_out(fv), .lane_out(fl));

   assign cv[0] = fv;
   assign cl[0] = fl;
   assign cp[0] = '0;

   genvar g;
   for (g = 0; g < NS; g++) begin : g_cell
      q2e_cordic_cell #(.STEP(g)) u_cell (
         .clock, .reset, .en, .valid_in(cv[g]), .lane_in(cl[g]), .pass_in(cp[g]),
         .valid_out(cv[g+1]), .lane_out(cl[g+1]), .pass_out(cp[g+1]));
   end

   function automatic logic [ANG_W-1:0] to_out(input ang_type z, input int lim_deg,
                                               input int w);
      logic signed [ZW:0] r;
      logic signed [ZW:0] lim;
      r = (ZW+1)'(z + (ang_type'(1) <<< (S-1))) >>> S;
      lim = (ZW+1)'(lim_deg) <<< ANGLE_FRAC_BITS;
      if (lim > ((ZW+1)'(1) <<< (w-1)) - 1) lim = ((ZW+1)'(1) <<< (w-1)) - 1;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return ANG_W'(r);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= cv[NS];
      end
      if (en) begin
         out_d_ff <= {to_out(cl[NS][2].z, 180, ANG_W),
                      to_out(cl[NS][1].z, 180, ANG_W),
                      PITCH_W'(to_out(cl[NS][0].z, 90, PITCH_W))};
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {1'b0, out_d_ff};
   logic unused_pass;
   assign unused_pass = ^cp[NS];

   // a held word never changes while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");
   // pitch never outside +-90 degrees
   a_pitch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[14:0]) <= 15'sd11520
                      && $signed(rsp_tdata[14:0]) >= -15'sd11520))
      else $error("pitch out of range");
   // input is refused only behind a stalled result
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without cause");
endmodule

>>> rtl/q2e_cordic_cell.sv
// One CORDIC vectoring step cell with registered lanes for three angles.
`timescale 1ns / 1ps
module q2e_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                valid_in,
   input  q2e_pkg::lane_type   lane_in  [3],
   input  logic [q2e_pkg::PITCH_W+2*q2e_pkg::ANG_W-1:0] pass_in,
   output logic                valid_out,
   output q2e_pkg::lane_type   lane_out [3],
   output logic [q2e_pkg::PITCH_W+2*q2e_pkg::ANG_W-1:0] pass_out
);
   import q2e_pkg::*;
   lane_type lane_ff [3];
   lane_type lane_in_c [3];
   logic     valid_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lane_in_c[k] = lane_in[k];
         if (!lane_in[k].done) begin
            if (!lane_in[k].y[VW-1]) begin
               lane_in_c[k].x = lane_in[k].x + (lane_in[k].y >>> STEP);
               lane_in_c[k].y = lane_in[k].y - (lane_in[k].x >>> STEP);
               lane_in_c[k].z = lane_in[k].z + atan_tab(STEP);
            end else begin
               lane_in_c[k].x = lane_in[k].x - (lane_in[k].y >>> STEP);
               lane_in_c[k].y = lane_in[k].y + (lane_in[k].x >>> STEP);
               lane_in_c[k].z = lane_in[k].z - atan_tab(STEP);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         lane_ff  <= lane_in_c;
         pass_out <= pass_in;
      end
   end

   assign valid_out = valid_ff;
   assign lane_out  = lane_ff;
endmodule

>>> rtl/q2e_front.sv
// Front end: rotation terms, pitch cosine by pipelined square root, CORDIC setup.
`timescale 1ns / 1ps
module q2e_front #(
   parameter int QUAT_FRAC_BITS = q2e_pkg::QUAT_FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              valid_in,
   input  logic signed [q2e_pkg::IN_W-1:0] q_w,
   input  logic signed [q2e_pkg::IN_W-1:0] q_x,
   input  logic signed [q2e_pkg::IN_W-1:0] q_y,
   input  logic signed [q2e_pkg::IN_W-1:0] q_z,
   output logic              valid_out,
   output q2e_pkg::lane_type lane_out [3]
);
   import q2e_pkg::*;
   localparam int SH  = 2 * QUAT_FRAC_BITS - WORK_FRAC;
   // raw product-sum width: holds 2^(2*QUAT_FRAC_BITS) and 2^32 with sign
   localparam int PW  = ((2 * QUAT_FRAC_BITS > 32) ? 2 * QUAT_FRAC_BITS : 32) + 4;
   localparam int TWQ = PW - SH;       // working-scale term width
   localparam int SQ  = 31;            // root bits

   // stage 1: products
   logic signed [31:0] p_ff [10];
   logic               v1_ff;
   // stage 2: terms at working scale
   logic signed [TWQ-1:0] t_ff [5];
   logic                  v2_ff;
   // stage 3: t2 squared and radicand
   logic [61:0] rad_ff;
   logic signed [TWQ-1:0] ts_ff [5];
   logic v3_ff;
   // square root cells, one result bit a stage
   logic [61:0] rem_ff [SQ+1];
   logic [SQ-1:0] root_ff [SQ+1];
   logic signed [TWQ-1:0] sr_t_ff [SQ+1][5];
   logic v_sq_ff [SQ+1];
   // normalize stages
   lane_type nl_ff [3];
   logic     vn_ff;
   lane_type pre_c [3];
   lane_type pre_ff [3];
   logic     vp_ff;

   function automatic logic signed [TWQ-1:0] to_work(input logic signed [PW-1:0] v);
      logic signed [PW+WORK_FRAC-1:0] e;
      e = (PW+WORK_FRAC)'(v);
      if (SH >= 0) return TWQ'(e >>> SH);
      else         return TWQ'(e <<< (-SH));
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= q_y * q_y;  p_ff[1] <= q_z * q_z;
         p_ff[2] <= q_x * q_y;  p_ff[3] <= q_w * q_z;
         p_ff[4] <= q_w * q_y;  p_ff[5] <= q_x * q_z;
         p_ff[6] <= q_y * q_z;  p_ff[7] <= q_w * q_x;
         p_ff[8] <= q_x * q_x;  p_ff[9] <= q_y * q_y;
         t_ff[0] <= to_work((PW'(1) <<< (2*QUAT_FRAC_BITS))
                            - 2 * (PW'(p_ff[0]) + PW'(p_ff[1])));
         t_ff[1] <= to_work(2 * (PW'(p_ff[2]) + PW'(p_ff[3])));
         t_ff[2] <= to_work(2 * (PW'(p_ff[4]) - PW'(p_ff[5])));
         t_ff[3] <= to_work(2 * (PW'(p_ff[6]) + PW'(p_ff[7])));
         t_ff[4] <= to_work((PW'(1) <<< (2*QUAT_FRAC_BITS))
                            - 2 * (PW'(p_ff[8]) + PW'(p_ff[9])));
      end
   end

   // clamp t2 and form 2^60 - t2^2
   logic signed [TWQ-1:0] t2c;
   logic [30:0] a2;
   logic [61:0] a2sq;
   always_comb begin
      t2c = t_ff[2];
      if (t_ff[2] > (TWQ'(1) <<< WORK_FRAC)) t2c = TWQ'(1) <<< WORK_FRAC;
      if (t_ff[2] < -(TWQ'(1) <<< WORK_FRAC)) t2c = -(TWQ'(1) <<< WORK_FRAC);
      a2 = t2c[TWQ-1] ? 31'(-t2c) : 31'(t2c);
      a2sq = a2 * a2;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff <= (62'(1) << 60) - a2sq;
         ts_ff[0] <= t_ff[0];
         ts_ff[1] <= t_ff[1];
         ts_ff[2] <= t2c;
         ts_ff[3] <= t_ff[3];
         ts_ff[4] <= t_ff[4];
         rem_ff[0]  <= rad_ff;
         root_ff[0] <= '0;
         sr_t_ff[0] <= ts_ff;
      end
   end

   // restoring square root, bit SQ-1-k decided in cell k
   genvar g;
   for (g = 0; g < SQ; g++) begin : g_sqrt
      localparam int B = SQ - 1 - g;
      always_ff @(posedge clock) begin
         if (en) begin
            sr_t_ff[g+1] <= sr_t_ff[g];
            if (63'(rem_ff[g]) >= ((63'(root_ff[g]) << (B+1)) | (63'(1) << (2*B)))) begin
               rem_ff[g+1]  <= 62'(63'(rem_ff[g]) - ((63'(root_ff[g]) << (B+1))
                               | (63'(1) << (2*B))));
               root_ff[g+1] <= root_ff[g] | (SQ'(1) << B);
            end else begin
               rem_ff[g+1]  <= rem_ff[g];
               root_ff[g+1] <= root_ff[g];
            end
         end
      end
   end

   // valid pipe through the front
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         v_sq_ff[0] <= 1'b0; vn_ff <= 1'b0; vp_ff <= 1'b0;
         for (int k = 1; k <= SQ; k++) v_sq_ff[k] <= 1'b0;
      end else if (en) begin
         v1_ff <= valid_in; v2_ff <= v1_ff; v3_ff <= v2_ff;
         v_sq_ff[0] <= v3_ff;
         for (int k = 1; k <= SQ; k++) v_sq_ff[k] <= v_sq_ff[k-1];
         vn_ff <= v_sq_ff[SQ];
         vp_ff <= vn_ff;
      end
   end

   // operand pairs (y, x): pitch (t2, c), roll (t3, t4), yaw (t1, t0)
   vec_type ya [3], xa [3];
   always_comb begin
      ya[0] = VW'(sr_t_ff[SQ][2]); xa[0] = VW'(signed'({1'b0, root_ff[SQ]}));
      ya[1] = VW'(sr_t_ff[SQ][3]); xa[1] = VW'(sr_t_ff[SQ][4]);
      ya[2] = VW'(sr_t_ff[SQ][1]); xa[2] = VW'(sr_t_ff[SQ][0]);
   end

   // normalize: shift left until max magnitude reaches 2^44; larger stays as is
   function automatic int lead_shift(input vec_type x, input vec_type y);
      logic [VW-1:0] m;
      int s;
      m = (x[VW-1] ? VW'(-x) : x) | (y[VW-1] ? VW'(-y) : y);
      s = 0;
      for (int b = 0; b < VW; b++) if (m[b]) s = (b >= 44) ? 0 : 44 - b;
      return s;
   endfunction

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pre_c[k] = nl_ff[k];
         if (!nl_ff[k].done && nl_ff[k].x[VW-1]) begin
            if (!nl_ff[k].y[VW-1]) begin
               pre_c[k].x = nl_ff[k].y;
               pre_c[k].y = -nl_ff[k].x;
               pre_c[k].z = ang_type'(90) <<< DEG_FRAC;
            end else begin
               pre_c[k].x = -nl_ff[k].y;
               pre_c[k].y = nl_ff[k].x;
               pre_c[k].z = -(ang_type'(90) <<< DEG_FRAC);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            nl_ff[k].done <= (ya[k] == '0) || (xa[k] == '0);
            if (ya[k] == '0)
               nl_ff[k].z <= xa[k][VW-1] ? ang_type'(180) <<< DEG_FRAC : '0;
            else if (xa[k] == '0)
               nl_ff[k].z <= ya[k][VW-1] ? -(ang_type'(90) <<< DEG_FRAC)
                                         : ang_type'(90) <<< DEG_FRAC;
            else
               nl_ff[k].z <= '0;
            nl_ff[k].x <= xa[k] <<< lead_shift(xa[k], ya[k]);
            nl_ff[k].y <= ya[k] <<< lead_shift(xa[k], ya[k]);
         end
         pre_ff <= pre_c;
      end
   end

   assign valid_out = vp_ff;
   assign lane_out  = pre_ff;
   logic unused_rem;
   assign unused_rem = ^rem_ff[SQ];
endmodule
